// ===== rtl/lmcd_pkg.sv =====
// Types and constants for the LED matrix chain frame driver.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package lmcd_pkg;

   // store geometry: column = 8*device + digit
   localparam int DIGITS      = 8;
   localparam int DIGIT_W     = 3;
   localparam int STORE_DEPTH = 128;
   localparam int STORE_AW    = 7;
   localparam int CHIP_W      = STORE_AW - DIGIT_W;

   // action codes on the request port
   localparam logic [2:0] ACT_SET_DOT        = 3'd0;
   localparam logic [2:0] ACT_SET_COLUMN     = 3'd1;
   localparam logic [2:0] ACT_SET_COLUMN_ALL = 3'd2;
   localparam logic [2:0] ACT_COMMAND        = 3'd3;
   localparam logic [2:0] ACT_REFRESH_DIGIT  = 3'd4;

   // no-op word sent to devices that are not addressed
   localparam logic [7:0] NOOP_ADDRESS = 8'h00;
   localparam logic [7:0] NOOP_DATA    = 8'h00;

   typedef enum logic [2:0] {
      OP_DOT,
      OP_COLUMN,
      OP_COLUMN_ALL,
      OP_COMMAND,
      OP_REFRESH
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MODIFY,
      ST_EMIT
   } state_type;

   // one classified item waiting for the sequencer
   typedef struct packed {
      op_type               op;
      logic [STORE_AW-1:0]  column;
      logic [2:0]           row;
      logic [7:0]           value;
      logic [7:0]           command_address;
   } job_type;

endpackage

// ===== rtl/led_matrix_chain_frame_driver_core.sv =====
// LED matrix daisy-chain frame driver, top level.
// After an item leaves the queue: set_column, set_column_all and command go straight to emit,
// refresh_digit first passes a fetch state, set_dot fetch and modify; then one word per cycle
// for N chips. The next item is taken only after the last word; unknown actions never queue.
// Reset (synchronous): queue empty, chain length 1, column store reads as all zeros.
// Depends on lmcd_pkg, lmcd_front, lmcd_queue, lmcd_back.
`timescale 1ns / 1ps

module led_matrix_chain_frame_driver_core #(
   parameter int MAX_DEVICES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [6:0]  req_column,
   input  logic [2:0]  req_row,
   input  logic [7:0]  req_value,
   input  logic [7:0]  req_command_address,
   output logic        rsp_valid,
   output logic [7:0]  rsp_reg_address,
   output logic [7:0]  rsp_reg_data,
   output logic        rsp_last_word,
   input  logic        csr_write_enable,
   input  logic [4:0]  csr_write_data
);

   localparam int DEV_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

   logic [4:0]        device_count_ff;
   logic [DEV_W-1:0]  last_index;
   logic              push;
   logic              pop;
   logic              not_empty;
   lmcd_pkg::job_type push_job;
   lmcd_pkg::job_type head_job;

   // chain length register
   always_ff @(posedge clock) begin
      if (reset) begin
         device_count_ff <= 5'd1;
      end else if (csr_write_enable) begin
         device_count_ff <= csr_write_data;
      end
   end

   // clamp chain length to 1..MAX_DEVICES, as index of the final word
   always_comb begin
      if (device_count_ff == 5'd0) begin
         last_index = '0;
      end else if (device_count_ff > 5'(MAX_DEVICES)) begin
         last_index = DEV_W'(MAX_DEVICES - 1);
      end else begin
         last_index = DEV_W'(device_count_ff - 5'd1);
      end
   end

   lmcd_front u_front (
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_column          (req_column),
      .req_row             (req_row),
      .req_value           (req_value),
      .req_command_address (req_command_address),
      .push                (push),
      .job                 (push_job)
   );

   lmcd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .head_job  (head_job),
      .not_empty (not_empty),
      .full      (busy)
   );

   lmcd_back #(
      .DEV_W       (DEV_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_ready       (not_empty),
      .head_job        (head_job),
      .last_index      (last_index),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_reg_address (rsp_reg_address),
      .rsp_reg_data    (rsp_reg_data),
      .rsp_last_word   (rsp_last_word)
   );

endmodule

// ===== rtl/lmcd_front.sv =====
// Front end: takes request items, decodes the action and drops unknown codes.
// Depends on lmcd_pkg.
`timescale 1ns / 1ps

module lmcd_front (
   input  logic                          start,
   input  logic                          busy,
   input  logic [2:0]                    req_action,
   input  logic [lmcd_pkg::STORE_AW-1:0] req_column,
   input  logic [2:0]                    req_row,
   input  logic [7:0]                    req_value,
   input  logic [7:0]                    req_command_address,
   output logic                          push,
   output lmcd_pkg::job_type             job
);

   logic known;

   // decode the action code into an operation
   always_comb begin
      known  = 1'b1;
      job.op = lmcd_pkg::OP_DOT;
      case (req_action)
         lmcd_pkg::ACT_SET_DOT:        job.op = lmcd_pkg::OP_DOT;
         lmcd_pkg::ACT_SET_COLUMN:     job.op = lmcd_pkg::OP_COLUMN;
         lmcd_pkg::ACT_SET_COLUMN_ALL: job.op = lmcd_pkg::OP_COLUMN_ALL;
         lmcd_pkg::ACT_COMMAND:        job.op = lmcd_pkg::OP_COMMAND;
         lmcd_pkg::ACT_REFRESH_DIGIT:  job.op = lmcd_pkg::OP_REFRESH;
         default:                      known  = 1'b0;
      endcase
      job.column          = req_column;
      job.row             = req_row;
      job.value           = req_value;
      job.command_address = req_command_address;
   end

   // unknown actions are accepted but never reach the queue
   assign push = start && !busy && known;

endmodule

// ===== rtl/lmcd_queue.sv =====
// Two-entry queue of decoded items between front end and sequencer.
// Depends on lmcd_pkg.
`timescale 1ns / 1ps

module lmcd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lmcd_pkg::job_type push_job,
   input  logic              pop,
   output lmcd_pkg::job_type head_job,
   output logic              not_empty,
   output logic              full
);

   lmcd_pkg::job_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   assign not_empty = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign head_job  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry payload, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/lmcd_back.sv =====
// Back end: word sequencer and column store, one device word per cycle.
// Depends on lmcd_pkg.
`timescale 1ns / 1ps

module lmcd_back #(
   parameter int DEV_W = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_ready,
   input  lmcd_pkg::job_type head_job,
   input  logic [DEV_W-1:0]  last_index,
   output logic              pop,
   output logic              rsp_valid,
   output logic [7:0]        rsp_reg_address,
   output logic [7:0]        rsp_reg_data,
   output logic              rsp_last_word
);

   localparam int AW = lmcd_pkg::STORE_AW;
   localparam int CW = lmcd_pkg::CHIP_W;

   lmcd_pkg::state_type state_ff, state_in;
   lmcd_pkg::job_type   job_ff;
   logic [DEV_W-1:0]    word_ff;
   logic [7:0]          dot_ff;

   // column store with per-entry valid bits (unwritten entries read zero)
   logic [7:0]                        store_mem [lmcd_pkg::STORE_DEPTH];
   logic [lmcd_pkg::STORE_DEPTH-1:0]  valid_ff;
   logic [7:0]                        rd_raw_ff;
   logic                              rd_valid_ff;
   logic [7:0]                        rd_data;

   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [7:0]           mem_wdata;
   logic [AW-1:0]        mem_raddr;

   logic [lmcd_pkg::DIGIT_W-1:0] digit;
   logic [CW-1:0]                chip;
   logic [CW-1:0]                word_chip;
   logic [7:0]                   digit_address;
   logic [7:0]                   dot_mask;
   logic [7:0]                   dot_new;
   logic                         is_target;
   logic                         is_last;

   assign digit         = job_ff.column[lmcd_pkg::DIGIT_W-1:0];
   assign chip          = job_ff.column[AW-1:lmcd_pkg::DIGIT_W];
   assign word_chip     = CW'(word_ff);
   assign digit_address = 8'(digit) + 8'd1;
   assign dot_mask      = 8'd1 << job_ff.row;
   assign dot_new       = job_ff.value[0] ? (rd_data | dot_mask) : (rd_data & ~dot_mask);
   assign is_target     = (word_chip == chip);
   assign is_last       = (word_ff == last_index);
   assign rd_data       = rd_valid_ff ? rd_raw_ff : 8'h00;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lmcd_pkg::ST_IDLE: begin
            if (job_ready) begin
               if (head_job.op == lmcd_pkg::OP_DOT || head_job.op == lmcd_pkg::OP_REFRESH) begin
                  state_in = lmcd_pkg::ST_FETCH;
               end else begin
                  state_in = lmcd_pkg::ST_EMIT;
               end
            end
         end
         lmcd_pkg::ST_FETCH: begin
            if (job_ff.op == lmcd_pkg::OP_DOT) begin
               state_in = lmcd_pkg::ST_MODIFY;
            end else begin
               state_in = lmcd_pkg::ST_EMIT;
            end
         end
         lmcd_pkg::ST_MODIFY: state_in = lmcd_pkg::ST_EMIT;
         lmcd_pkg::ST_EMIT: begin
            if (is_last) begin
               state_in = lmcd_pkg::ST_IDLE;
            end
         end
         default: state_in = lmcd_pkg::ST_IDLE;
      endcase
   end

   // outputs and store access
   always_comb begin
      pop             = 1'b0;
      rsp_valid       = 1'b0;
      rsp_reg_address = lmcd_pkg::NOOP_ADDRESS;
      rsp_reg_data    = lmcd_pkg::NOOP_DATA;
      rsp_last_word   = 1'b0;
      mem_we          = 1'b0;
      mem_waddr       = job_ff.column;
      mem_wdata       = job_ff.value;
      mem_raddr       = {CW'(0), digit};
      case (state_ff)
         lmcd_pkg::ST_IDLE: pop = job_ready;
         lmcd_pkg::ST_FETCH: begin
            if (job_ff.op == lmcd_pkg::OP_DOT) begin
               mem_raddr = job_ff.column;
            end
         end
         lmcd_pkg::ST_MODIFY: begin
            mem_we    = 1'b1;
            mem_wdata = dot_new;
         end
         lmcd_pkg::ST_EMIT: begin
            rsp_valid     = 1'b1;
            rsp_last_word = is_last;
            // prefetch the next device's column for refresh
            mem_raddr     = {word_chip + CW'(1), digit};
            case (job_ff.op)
               lmcd_pkg::OP_DOT: begin
                  if (is_target) begin
                     rsp_reg_address = digit_address;
                     rsp_reg_data    = dot_ff;
                  end
               end
               lmcd_pkg::OP_COLUMN: begin
                  mem_we = (word_ff == '0);
                  if (is_target) begin
                     rsp_reg_address = digit_address;
                     rsp_reg_data    = job_ff.value;
                  end
               end
               lmcd_pkg::OP_COLUMN_ALL: begin
                  mem_we          = 1'b1;
                  mem_waddr       = {word_chip, digit};
                  rsp_reg_address = digit_address;
                  rsp_reg_data    = job_ff.value;
               end
               lmcd_pkg::OP_COMMAND: begin
                  rsp_reg_address = job_ff.command_address;
                  rsp_reg_data    = job_ff.value;
               end
               lmcd_pkg::OP_REFRESH: begin
                  rsp_reg_address = digit_address;
                  rsp_reg_data    = rd_data;
               end
               default: rsp_valid = 1'b0;
            endcase
         end
         default: pop = 1'b0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lmcd_pkg::ST_IDLE;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (pop || state_ff != lmcd_pkg::ST_EMIT) begin
            word_ff <= '0;
         end else begin
            word_ff <= word_ff + DEV_W'(1);
         end
      end
   end

   // job payload and modified dot column
   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= head_job;
      end
      if (state_ff == lmcd_pkg::ST_MODIFY) begin
         dot_ff <= dot_new;
      end
   end

   // store array, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      rd_raw_ff <= store_mem[mem_raddr];
   end

   // valid bits give the all-zero reset image
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            valid_ff[mem_waddr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[mem_raddr];
      end
   end

endmodule
